[design/anm_pkg.sv]
// Shared types, widths and fixed coefficients of the nonlinear audio mixer.
// No dependencies; imported by every module of the mixer.
package anm_pkg;

	localparam int FRAC_BITS = 16;
	localparam int LVL_W     = 4;
	localparam int DELTA_W   = 7;
	localparam int OUT_W     = 16;

	localparam int PN_W  = LVL_W + 1;
	localparam int T_W   = 35;
	localparam int DIV_W = 50;
	localparam int Q_W   = FRAC_BITS + 1;
	localparam int SAT_W = (Q_W > OUT_W + 1) ? Q_W : OUT_W + 1;

	localparam longint unsigned TRI_DIV   = 64'd8227;
	localparam longint unsigned NOISE_DIV = 64'd12241;
	localparam longint unsigned DELTA_DIV = 64'd22638;

	// group t scaled by TRI_DIV * NOISE_DIV * DELTA_DIV
	localparam logic [T_W-1:0] TRI_K   = T_W'(NOISE_DIV * DELTA_DIV);
	localparam logic [T_W-1:0] NOISE_K = T_W'(TRI_DIV * DELTA_DIV);
	localparam logic [T_W-1:0] DELTA_K = T_W'(TRI_DIV * NOISE_DIV);

	localparam logic [DIV_W-1:0] TND_NUM      = DIV_W'(64'd15979);
	localparam logic [DIV_W-1:0] TND_DEN_BASE = DIV_W'(64'd100 * TRI_DIV * NOISE_DIV * DELTA_DIV);
	localparam logic [DIV_W-1:0] TND_DEN_STEP = DIV_W'(64'd10000);

	localparam logic [DIV_W-1:0] PULSE_NUM      = DIV_W'(64'd9588);
	localparam logic [DIV_W-1:0] PULSE_DEN_BASE = DIV_W'(64'd812800);
	localparam logic [DIV_W-1:0] PULSE_DEN_STEP = DIV_W'(64'd10000);

	localparam logic [OUT_W-1:0] OUT_MAX = '1;

	typedef struct packed {
		logic [DIV_W-1:0] num;
		logic [DIV_W-1:0] den;
	} frac_t;

	typedef struct packed {
		logic  valid;
		frac_t pulse;
		frac_t tnd;
	} div_req_t;

	typedef struct packed {
		logic           valid;
		logic [Q_W-1:0] pulse_q;
		logic [Q_W-1:0] tnd_q;
	} div_res_t;

	function automatic logic [OUT_W-1:0] sat_out(input logic [SAT_W-1:0] v);
		return (v > SAT_W'(OUT_MAX)) ? OUT_MAX : v[OUT_W-1:0];
	endfunction

endpackage

[design/anm_prep.sv]
// Front end of the mixer: level sums, then numerator and denominator of each group.
// Depends on anm_pkg.
module anm_prep (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            en,
	input  logic                            in_valid,
	input  logic [anm_pkg::LVL_W-1:0]       pulse_a_level,
	input  logic [anm_pkg::LVL_W-1:0]       pulse_b_level,
	input  logic [anm_pkg::LVL_W-1:0]       tri_level,
	input  logic [anm_pkg::LVL_W-1:0]       noise_level,
	input  logic [anm_pkg::DELTA_W-1:0]     delta_level,
	output anm_pkg::div_req_t               req
);
	import anm_pkg::*;

	logic             v_s1;
	logic [PN_W-1:0]  n_s1;
	logic [T_W-1:0]   t_s1;
	logic             v_s2;
	frac_t            pulse_s2;
	frac_t            tnd_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			n_s1 <= PN_W'(pulse_a_level) + PN_W'(pulse_b_level);
			t_s1 <= T_W'(tri_level) * TRI_K + T_W'(noise_level) * NOISE_K
				+ T_W'(delta_level) * DELTA_K;
			pulse_s2.num <= PULSE_NUM * DIV_W'(n_s1);
			pulse_s2.den <= PULSE_DEN_BASE + PULSE_DEN_STEP * DIV_W'(n_s1);
			tnd_s2.num   <= TND_NUM * DIV_W'(t_s1);
			tnd_s2.den   <= TND_DEN_BASE + TND_DEN_STEP * DIV_W'(t_s1);
		end
	end

	assign req.valid = v_s2;
	assign req.pulse = pulse_s2;
	assign req.tnd   = tnd_s2;

endmodule

[design/anm_div.sv]
// Pipelined restoring divider, two lanes, one quotient bit per stage.
// Gives floor(num * 2^FRAC_BITS / den) for num < 2 * den. Depends on anm_pkg.
module anm_div (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              en,
	input  anm_pkg::div_req_t req,
	output anm_pkg::div_res_t res
);
	import anm_pkg::*;

	localparam int STAGES = FRAC_BITS + 1;
	localparam int LANES  = 2;

	frac_t            lane_in [LANES];
	logic             v_s     [STAGES];
	logic [DIV_W-1:0] rem_s   [LANES][STAGES];
	logic [DIV_W-1:0] den_s   [LANES][STAGES];
	logic [Q_W-1:0]   q_s     [LANES][STAGES];
	logic [DIV_W-1:0] rin_c   [LANES][STAGES];
	logic [DIV_W-1:0] din_c   [LANES][STAGES];
	logic [Q_W-1:0]   qin_c   [LANES][STAGES];
	logic             bit_c   [LANES][STAGES];

	assign lane_in[0] = req.pulse;
	assign lane_in[1] = req.tnd;

	for (genvar k = 0; k < STAGES; k++) begin : g_stage
		if (k == 0) begin : g_first
			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n)
					v_s[k] <= 1'b0;
				else if (en)
					v_s[k] <= req.valid;
			end
		end else begin : g_next
			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n)
					v_s[k] <= 1'b0;
				else if (en)
					v_s[k] <= v_s[k-1];
			end
		end

		for (genvar l = 0; l < LANES; l++) begin : g_lane
			if (k == 0) begin : g_load
				assign rin_c[l][k] = lane_in[l].num;
				assign din_c[l][k] = lane_in[l].den;
				assign qin_c[l][k] = '0;
			end else begin : g_shift
				assign rin_c[l][k] = {rem_s[l][k-1][DIV_W-2:0], 1'b0};
				assign din_c[l][k] = den_s[l][k-1];
				assign qin_c[l][k] = q_s[l][k-1];
			end

			assign bit_c[l][k] = (rin_c[l][k] >= din_c[l][k]);

			always_ff @(posedge clk) begin
				if (en) begin
					rem_s[l][k] <= bit_c[l][k] ? rin_c[l][k] - din_c[l][k] : rin_c[l][k];
					den_s[l][k] <= din_c[l][k];
					q_s[l][k]   <= {qin_c[l][k][Q_W-2:0], bit_c[l][k]};
				end
			end
		end
	end

	assign res.valid   = v_s[STAGES-1];
	assign res.pulse_q = q_s[0][STAGES-1];
	assign res.tnd_q   = q_s[1][STAGES-1];

endmodule

[design/audio_nonlinear_mixer.sv]
// Top level of the nonlinear audio mixer: front end, divider and output stage.
// Depends on anm_pkg, anm_prep and anm_div.
//
// channel  dir  width  contents
// s_*      in   24     level set per request
// m_*      out  48     pulse term, tnd term, saturated mix
//
// The pipeline has two front-end stages, FRAC_BITS + 1 divider
// stages and one output stage.
// One request is taken per cycle unless the output stalls; the whole pipeline advances together.
// While a result waits on m_tready, every stage holds and s_tready is low.
// Reset clears the valid bits only.
module audio_nonlinear_mixer (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	// [3:0] pulse_a_level, [7:4] pulse_b_level, [11:8] tri_level,
	// [15:12] noise_level, [22:16] delta_level, [23] zero
	input  logic [23:0] s_tdata,
	output logic        m_tvalid,
	input  logic        m_tready,
	// [15:0] pulse_part, [31:16] tnd_part, [47:32] mixed_out
	output logic [47:0] m_tdata
);
	import anm_pkg::*;

	logic               adv;
	div_req_t           req;
	div_res_t           res;
	logic [OUT_W-1:0]   pulse_c;
	logic [OUT_W-1:0]   tnd_c;
	logic               out_v_q;
	logic [OUT_W-1:0]   pulse_q;
	logic [OUT_W-1:0]   tnd_q;
	logic [OUT_W-1:0]   mixed_q;

	assign adv      = !out_v_q || m_tready;
	assign s_tready = adv;

	anm_prep u_prep (
		.clk           (clk),
		.arst_n        (arst_n),
		.en            (adv),
		.in_valid      (s_tvalid),
		.pulse_a_level (s_tdata[3:0]),
		.pulse_b_level (s_tdata[7:4]),
		.tri_level     (s_tdata[11:8]),
		.noise_level   (s_tdata[15:12]),
		.delta_level   (s_tdata[22:16]),
		.req           (req)
	);

	anm_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (adv),
		.req    (req),
		.res    (res)
	);

	assign pulse_c = sat_out(SAT_W'(res.pulse_q));
	assign tnd_c   = sat_out(SAT_W'(res.tnd_q));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_v_q <= 1'b0;
		else if (adv)
			out_v_q <= res.valid;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			pulse_q <= pulse_c;
			tnd_q   <= tnd_c;
			mixed_q <= sat_out(SAT_W'(pulse_c) + SAT_W'(tnd_c));
		end
	end

	assign m_tvalid = out_v_q;
	assign m_tdata  = {mixed_q, tnd_q, pulse_q};

endmodule
